// ----- rtl/deqavg_pkg.sv -----
package deqavg_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int AVG_W    = 40;
  localparam int ST_W     = 2;

  // running sum holds up to CAPACITY full-scale values
  localparam int SUM_W    = VAL_W + PTR_W;
  localparam int FRAC_W   = 8;
  localparam int DVD_W    = SUM_W + FRAC_W;
  localparam int DCNT_W   = $clog2(DVD_W);

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_AVERAGE    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // -1.0 in Q8
  localparam logic signed [AVG_W-1:0] AVG_EMPTY = AVG_W'(-(1 <<< FRAC_W));

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_AVERAGE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DIV
  } back_state_t;

endpackage

// ----- rtl/deqavg_front.sv -----
module deqavg_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [deqavg_pkg::CMD_W-1:0]       in_command,
  input  logic signed [deqavg_pkg::VAL_W-1:0] in_value,
  output logic                               q_valid,
  output deqavg_pkg::item_t                  q_item,
  input  logic                               q_stall
);

  logic              valid_r;
  logic              valid_nxt;
  deqavg_pkg::item_t item_r;
  deqavg_pkg::op_t   op_dec;

  always_comb begin
    unique case (in_command)
      deqavg_pkg::CMD_PUSH_FRONT: op_dec = deqavg_pkg::OP_PUSH_FRONT;
      deqavg_pkg::CMD_PUSH_BACK:  op_dec = deqavg_pkg::OP_PUSH_BACK;
      deqavg_pkg::CMD_POP_FRONT:  op_dec = deqavg_pkg::OP_POP_FRONT;
      deqavg_pkg::CMD_POP_BACK:   op_dec = deqavg_pkg::OP_POP_BACK;
      deqavg_pkg::CMD_AVERAGE:    op_dec = deqavg_pkg::OP_AVERAGE;
      default:                    op_dec = deqavg_pkg::OP_NOP;
    endcase
  end

  // hold while the queue refuses the staged item
  assign in_stall  = valid_r && q_stall;
  assign valid_nxt = (valid_r && q_stall) || in_valid;
  assign q_valid   = valid_r;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.op    <= op_dec;
      item_r.value <= in_value;
    end
  end

endmodule

// ----- rtl/deqavg_queue.sv -----
module deqavg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deqavg_pkg::item_t in_item,
  output logic              out_valid,
  output deqavg_pkg::item_t out_item,
  input  logic              out_stall
);

  deqavg_pkg::item_t                   mem_r [deqavg_pkg::QDEPTH];
  logic [deqavg_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [deqavg_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [deqavg_pkg::QCNT_W-1:0]       cnt_r;
  logic                                wr_en;
  logic                                rd_en;

  function automatic logic [deqavg_pkg::QPTR_W-1:0] ptr_inc(
    input logic [deqavg_pkg::QPTR_W-1:0] p
  );
    if (p == deqavg_pkg::QPTR_W'(deqavg_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign in_stall  = (cnt_r == deqavg_pkg::QCNT_W'(deqavg_pkg::QDEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign wr_en     = in_valid && !in_stall;
  assign rd_en     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ----- rtl/deqavg_div.sv -----
module deqavg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [deqavg_pkg::DVD_W-1:0]   dividend,
  input  logic [deqavg_pkg::CNT_W-1:0]   divisor,
  output logic                           done,
  output logic [deqavg_pkg::DVD_W-1:0]   quotient
);

  logic                            busy_r;
  logic                            done_r;
  logic [deqavg_pkg::DCNT_W-1:0]   cnt_r;
  logic [deqavg_pkg::CNT_W-1:0]    rem_r;
  logic [deqavg_pkg::CNT_W-1:0]    dsr_r;
  logic [deqavg_pkg::DVD_W-1:0]    quo_r;
  logic [deqavg_pkg::CNT_W:0]      rem_sh;
  logic [deqavg_pkg::CNT_W:0]      rem_dif;
  logic                            ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r, quo_r[deqavg_pkg::DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr_r});
  assign rem_dif  = rem_sh - {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= deqavg_pkg::DCNT_W'(deqavg_pkg::DVD_W - 1);
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= ge ? rem_dif[deqavg_pkg::CNT_W-1:0] : rem_sh[deqavg_pkg::CNT_W-1:0];
      quo_r <= {quo_r[deqavg_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/deqavg_back.sv -----
module deqavg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  deqavg_pkg::item_t                   q_item,
  output logic                                q_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [deqavg_pkg::VAL_W-1:0] out_popped_value,
  output logic signed [deqavg_pkg::AVG_W-1:0] out_average_q8,
  output logic [deqavg_pkg::ST_W-1:0]         out_status,
  output logic [deqavg_pkg::CNT_W-1:0]        out_entry_count,
  output logic                                div_start,
  output logic [deqavg_pkg::DVD_W-1:0]        div_dividend,
  output logic [deqavg_pkg::CNT_W-1:0]        div_divisor,
  input  logic                                div_done,
  input  logic [deqavg_pkg::DVD_W-1:0]        div_quotient
);

  localparam int PTR_W = deqavg_pkg::PTR_W;
  localparam int CNT_W = deqavg_pkg::CNT_W;
  localparam int SUM_W = deqavg_pkg::SUM_W;
  localparam int VAL_W = deqavg_pkg::VAL_W;
  localparam int AVG_W = deqavg_pkg::AVG_W;
  localparam int ST_W  = deqavg_pkg::ST_W;

  deqavg_pkg::back_state_t state_r, state_nxt;
  logic [PTR_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    neg_r, neg_nxt;

  logic signed [VAL_W-1:0] mem_r [deqavg_pkg::CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;
  logic                    mem_we;
  logic                    mem_re;
  logic [PTR_W-1:0]        mem_waddr;
  logic [PTR_W-1:0]        mem_raddr;

  logic                    ov_r, ov_nxt;
  logic signed [VAL_W-1:0] opop_r, opop_nxt;
  logic signed [AVG_W-1:0] oavg_r, oavg_nxt;
  logic [ST_W-1:0]         ost_r, ost_nxt;
  logic [CNT_W-1:0]        ocnt_r, ocnt_nxt;

  logic                    out_free;
  logic                    dispatch;
  logic                    full;
  logic                    empty;
  logic [PTR_W-1:0]        front_dec;
  logic [PTR_W-1:0]        front_inc;
  logic [CNT_W:0]          back_idx;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [AVG_W-1:0] quo_avg;

  function automatic logic [PTR_W-1:0] wrap(input logic [CNT_W:0] idx);
    if (idx >= (CNT_W + 1)'(deqavg_pkg::CAPACITY)) begin
      return PTR_W'(idx - (CNT_W + 1)'(deqavg_pkg::CAPACITY));
    end
    return PTR_W'(idx);
  endfunction

  assign out_free  = !ov_r || !out_stall;
  assign dispatch  = (state_r == deqavg_pkg::BK_IDLE) && q_valid && out_free;
  assign q_stall   = !dispatch;
  assign full      = (occ_r == CNT_W'(deqavg_pkg::CAPACITY));
  assign empty     = (occ_r == '0);
  assign front_dec = (front_r == '0) ? PTR_W'(deqavg_pkg::CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == PTR_W'(deqavg_pkg::CAPACITY - 1)) ? '0 : front_r + 1'b1;
  assign back_idx  = (CNT_W + 1)'(front_r) + (CNT_W + 1)'(occ_r);

  assign sum_mag      = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_dividend = {sum_mag, deqavg_pkg::FRAC_W'(0)};
  assign div_divisor  = occ_r;
  assign quo_avg      = AVG_W'(div_quotient);

  assign out_valid        = ov_r;
  assign out_popped_value = opop_r;
  assign out_average_q8   = oavg_r;
  assign out_status       = ost_r;
  assign out_entry_count  = ocnt_r;

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    occ_nxt   = occ_r;
    sum_nxt   = sum_r;
    neg_nxt   = neg_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    div_start = 1'b0;
    ov_nxt    = ov_r && out_stall;
    opop_nxt  = opop_r;
    oavg_nxt  = oavg_r;
    ost_nxt   = ost_r;
    ocnt_nxt  = ocnt_r;

    unique case (state_r)
      deqavg_pkg::BK_IDLE: begin
        if (dispatch) begin
          // default result; commands below override what they produce
          ov_nxt   = 1'b1;
          opop_nxt = '0;
          oavg_nxt = '0;
          ost_nxt  = deqavg_pkg::ST_OK;
          ocnt_nxt = occ_r;
          unique case (q_item.op)
            deqavg_pkg::OP_PUSH_FRONT,
            deqavg_pkg::OP_PUSH_BACK: begin
              if (full) begin
                ost_nxt = deqavg_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (q_item.op == deqavg_pkg::OP_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  mem_waddr = front_dec;
                end else begin
                  mem_waddr = wrap(back_idx);
                end
                occ_nxt  = occ_r + 1'b1;
                ocnt_nxt = occ_r + 1'b1;
                sum_nxt  = sum_r + SUM_W'(q_item.value);
              end
            end
            deqavg_pkg::OP_POP_FRONT,
            deqavg_pkg::OP_POP_BACK: begin
              if (empty) begin
                ost_nxt = deqavg_pkg::ST_EMPTY;
              end else begin
                // result goes out once the read data lands
                ov_nxt = 1'b0;
                mem_re = 1'b1;
                if (q_item.op == deqavg_pkg::OP_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = front_inc;
                end else begin
                  mem_raddr = wrap(back_idx - 1'b1);
                end
                occ_nxt   = occ_r - 1'b1;
                state_nxt = deqavg_pkg::BK_READ;
              end
            end
            deqavg_pkg::OP_AVERAGE: begin
              if (empty) begin
                oavg_nxt = deqavg_pkg::AVG_EMPTY;
                ost_nxt  = deqavg_pkg::ST_EMPTY;
              end else begin
                ov_nxt    = 1'b0;
                div_start = 1'b1;
                neg_nxt   = sum_r[SUM_W-1];
                state_nxt = deqavg_pkg::BK_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      deqavg_pkg::BK_READ: begin
        sum_nxt   = sum_r - SUM_W'(rd_data_r);
        ov_nxt    = 1'b1;
        opop_nxt  = rd_data_r;
        oavg_nxt  = '0;
        ost_nxt   = deqavg_pkg::ST_OK;
        ocnt_nxt  = occ_r;
        state_nxt = deqavg_pkg::BK_IDLE;
      end
      deqavg_pkg::BK_DIV: begin
        if (div_done) begin
          ov_nxt    = 1'b1;
          opop_nxt  = '0;
          oavg_nxt  = neg_r ? -quo_avg : quo_avg;
          ost_nxt   = deqavg_pkg::ST_OK;
          ocnt_nxt  = occ_r;
          state_nxt = deqavg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = deqavg_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deqavg_pkg::BK_IDLE;
      front_r <= '0;
      occ_r   <= '0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    opop_r <= opop_nxt;
    oavg_r <= oavg_nxt;
    ost_r  <= ost_nxt;
    ocnt_r <= ocnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= q_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

endmodule

// ----- rtl/double_ended_queue_with_average.sv -----
// Path: push, failed pop and unused commands pass the front register and command queue
//   into the result register; a pop adds the storage read, an average the divider.
// Throughput: the back end retires a push or no-op every cycle unless its result stalls;
//   a pop waits in BK_READ, an average in BK_DIV; the front accepts until the queue fills.
// Reset: synchronous, active low; empties the deque, zeroes the sum and drops staged items.
//   Storage words are not cleared, only entries that were pushed are ever read.
module double_ended_queue_with_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [deqavg_pkg::CMD_W-1:0]        in_command,
  input  logic signed [deqavg_pkg::VAL_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [deqavg_pkg::VAL_W-1:0] out_popped_value,
  output logic signed [deqavg_pkg::AVG_W-1:0] out_average_q8,
  output logic [deqavg_pkg::ST_W-1:0]         out_status,
  output logic [deqavg_pkg::CNT_W-1:0]        out_entry_count
);

  // front stage -> command queue
  logic                            fq_valid;
  logic                            fq_stall;
  deqavg_pkg::item_t               fq_item;

  // command queue -> back end
  logic                            qb_valid;
  logic                            qb_stall;
  deqavg_pkg::item_t               qb_item;

  // back end <-> serial divider
  logic                            div_start;
  logic                            div_done;
  logic [deqavg_pkg::DVD_W-1:0]    div_dividend;
  logic [deqavg_pkg::CNT_W-1:0]    div_divisor;
  logic [deqavg_pkg::DVD_W-1:0]    div_quotient;

  // Front: register each item and decode its command into an operation.
  deqavg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .q_valid    (fq_valid),
    .q_item     (fq_item),
    .q_stall    (fq_stall)
  );

  // Queue: decouple the front from the back so a long average does not
  // freeze the input immediately.
  deqavg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_item  (qb_item),
    .out_stall (qb_stall)
  );

  // Back: own the ring store, the front pointer, the occupancy and the
  // running sum; execute one operation at a time and hold the result
  // in the output register until it is taken.
  deqavg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_item           (qb_item),
    .q_stall          (qb_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_average_q8   (out_average_q8),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_done         (div_done),
    .div_quotient     (div_quotient)
  );

  // Divider: |sum| * 256 / count, one quotient bit per cycle; the back
  // end restores the sign so the mean truncates toward zero.
  deqavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// ----- rtl/deqavg_checker.sv -----
module deqavg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [deqavg_pkg::VAL_W-1:0] out_popped_value,
  input logic signed [deqavg_pkg::AVG_W-1:0] out_average_q8,
  input logic [deqavg_pkg::ST_W-1:0]         out_status,
  input logic [deqavg_pkg::CNT_W-1:0]        out_entry_count
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_popped_value) &&
      $stable(out_average_q8) && $stable(out_status) && $stable(out_entry_count))
    else $error("result item changed while stalled");

  // an empty error only happens with nothing held
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deqavg_pkg::ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty error with entries held");

  // a full error only happens at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deqavg_pkg::ST_FULL) |->
      (out_entry_count == deqavg_pkg::CNT_W'(deqavg_pkg::CAPACITY)))
    else $error("full error below capacity");

  // a pop and an average never report in the same item
  a_pop_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_popped_value != '0) |->
      (out_average_q8 == '0) && (out_status == deqavg_pkg::ST_OK))
    else $error("popped value alongside average or error");

endmodule

bind double_ended_queue_with_average deqavg_checker u_deqavg_checker (.*);
